// ===== src/nrt_pkg.sv =====
package nrt_pkg;

  // default table geometry
  localparam int NRT_NODES  = 8;
  localparam int NRT_WINDOW = 5;

  localparam int LEVEL_W = 8;
  localparam int ID_W    = 16;
  localparam int DROP_W  = 8;

  // weakest level that can win; also the answer when no node is present
  localparam logic signed [LEVEL_W-1:0] FLOOR_LEVEL = -8'sd100;
  localparam logic [DROP_W-1:0]         DROP_RESET  = 8'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SREAD,
    ST_SCALC,
    ST_SDIV,
    ST_SWRITE,
    ST_AGE,
    ST_FIN
  } state_t;

endpackage

// ===== src/nrt_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned operands.
module nrt_div #(
  parameter int MAG_W = 11,
  parameter int DEN_W = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MAG_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [MAG_W-1:0] quotient
);

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [MAG_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] steps;
  logic             busy;

  logic [DEN_W:0]   trial;
  logic             take;
  logic [DEN_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, quo[MAG_W-1]};
    take     = (trial >= {1'b0, den});
    rem_next = take ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CNT_W'(MAG_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      quo <= {quo[MAG_W-2:0], take};
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

// ===== src/node_rssi_tracker_top.sv =====
// Per word: a match pass over the id memory, then the sample update (read, sum,
//   bit-serial divide with MAG_W = 8 + clog2(WINDOW), write), then an aging pass
//   and the result. A bad CRC skips the match and the update; a new id with the
//   table full skips the update. One word at a time; the next word can be taken
//   in the cycle after the result is loaded.
// Reset: slot table empty (fill count zero), drop_out_ticks = 10, no result held.
module node_rssi_tracker_top
  import nrt_pkg::*;
#(
  parameter int NODES  = NRT_NODES,
  parameter int WINDOW = NRT_WINDOW
) (
  input  logic                      clk,
  input  logic                      rst,
  // input words
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ID_W-1:0]           sender_id,
  input  logic signed [LEVEL_W-1:0] rssi,
  input  logic                      crc_ok,
  // result words
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [LEVEL_W-1:0] strongest_rssi,
  // configuration
  input  logic                      cfg_wr_en,
  input  logic [DROP_W-1:0]         cfg_wr_data
);

  localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = LEVEL_W + $clog2(WINDOW);

  // one slot's record in the data memory
  typedef struct packed {
    logic [WINDOW-1:0][LEVEL_W-1:0] hist;   // [0] oldest
    logic [CNT_W-1:0]               cnt;
    logic [LEVEL_W-1:0]             level;
    logic [DROP_W-1:0]              drop;
  } entry_t;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t state, state_next;

  logic [DROP_W-1:0]         drop_out_ticks;
  logic [IDX_W:0]            slots_used;     // slots fill in order and never free

  logic [ID_W-1:0]           sid;
  logic [LEVEL_W-1:0]        sample;

  logic [IDX_W:0]            walk_idx;       // next slot to read in a pass
  logic                      chk_vld;        // read data for chk_idx is present
  logic [IDX_W-1:0]          chk_idx;

  logic                      found;
  logic [IDX_W-1:0]          target;
  logic                      alloc;

  logic [WINDOW-1:0][LEVEL_W-1:0] samp_hist;
  logic [CNT_W-1:0]          samp_cnt;
  logic                      samp_neg;
  logic [LEVEL_W-1:0]        samp_level;

  logic signed [LEVEL_W-1:0] best;

  // memories, read data registered
  logic [ID_W-1:0]           id_mem [NODES];
  entry_t                    data_mem [NODES];
  logic [ID_W-1:0]           id_q;
  entry_t                    data_q;

  // ---------------------------------------------------------------------------
  // Combinational
  // ---------------------------------------------------------------------------
  logic                      accept;
  logic                      walking;
  logic                      issue;
  logic                      last;
  logic                      chk_in_table;
  logic                      hit_now;

  logic                      id_ren;
  logic                      id_we;
  logic                      d_ren;
  logic [IDX_W-1:0]          d_raddr;
  logic                      d_we;
  logic [IDX_W-1:0]          d_waddr;
  entry_t                    d_wdata;
  logic                      div_start;
  logic                      out_load;

  entry_t                    cur;
  logic [WINDOW-1:0][LEVEL_W-1:0] hist_n;
  logic [CNT_W-1:0]          cnt_n;
  logic signed [SUM_W-1:0]   sum;
  logic                      sum_neg;
  logic [SUM_W-1:0]          sum_mag;

  entry_t                    aged;
  logic signed [LEVEL_W-1:0] aged_lv;

  logic                      div_done;
  logic [SUM_W-1:0]          div_q;

  assign accept       = in_valid && in_ready;
  assign walking      = (state == ST_MATCH) || (state == ST_AGE);
  assign issue        = walking && (walk_idx < (IDX_W+1)'(NODES));
  assign last         = chk_vld && (chk_idx == IDX_W'(NODES - 1));
  assign chk_in_table = ({1'b0, chk_idx} < slots_used);
  assign hit_now      = (state == ST_MATCH) && chk_vld && chk_in_table && (id_q == sid);

  // take_sample: shift in the new word, sum the whole window (unfilled = 0)
  always_comb begin
    cur = alloc ? '0 : data_q;
    for (int h = 0; h < WINDOW - 1; h++) begin
      hist_n[h] = cur.hist[h+1];
    end
    hist_n[WINDOW-1] = sample;
    cnt_n = (cur.cnt < CNT_W'(WINDOW)) ? cur.cnt + 1'b1 : cur.cnt;
    sum = '0;
    for (int h = 0; h < WINDOW; h++) begin
      sum = sum + SUM_W'($signed(hist_n[h]));
    end
    sum_neg = sum[SUM_W-1];
    sum_mag = sum_neg ? SUM_W'(-sum) : SUM_W'(sum);
  end

  // aging of the slot under the walk
  always_comb begin
    aged = data_q;
    if (data_q.drop == '0) begin
      aged.level = '0;
    end else begin
      aged.drop = data_q.drop - 1'b1;
    end
    aged_lv = $signed(aged.level);
  end

  nrt_div #(
    .MAG_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (cnt_n),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = crc_ok ? ST_MATCH : ST_AGE;
      end
      ST_MATCH: begin
        if (last) begin
          if (found || hit_now || (slots_used < (IDX_W+1)'(NODES))) begin
            state_next = ST_SREAD;
          end else begin
            state_next = ST_AGE;
          end
        end
      end
      ST_SREAD:  state_next = ST_SCALC;
      ST_SCALC:  state_next = ST_SDIV;
      ST_SDIV: begin
        if (div_done) state_next = ST_SWRITE;
      end
      ST_SWRITE: state_next = ST_AGE;
      ST_AGE: begin
        if (last) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    id_ren    = 1'b0;
    id_we     = 1'b0;
    d_ren     = 1'b0;
    d_raddr   = walk_idx[IDX_W-1:0];
    d_we      = 1'b0;
    d_waddr   = chk_idx;
    d_wdata   = aged;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_MATCH: id_ren   = issue;
      ST_SREAD: begin
        d_ren   = 1'b1;
        d_raddr = target;
      end
      ST_SCALC: div_start = 1'b1;
      ST_SDIV:  ;
      ST_SWRITE: begin
        id_we         = alloc;
        d_we          = 1'b1;
        d_waddr       = target;
        d_wdata.hist  = samp_hist;
        d_wdata.cnt   = samp_cnt;
        d_wdata.level = samp_level;
        d_wdata.drop  = drop_out_ticks;
      end
      ST_AGE: begin
        d_ren = issue;
        d_we  = chk_vld && chk_in_table;
      end
      ST_FIN:   out_load = !out_valid || out_ready;
      default:  ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (id_we) id_mem[target] <= sid;
    if (id_ren) id_q <= id_mem[walk_idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (d_we) data_mem[d_waddr] <= d_wdata;
    if (d_ren) data_q <= data_mem[d_raddr];
  end

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      drop_out_ticks <= DROP_RESET;
      slots_used     <= '0;
      walk_idx       <= '0;
      chk_vld        <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) drop_out_ticks <= cfg_wr_data;
      if (id_we) slots_used <= slots_used + 1'b1;

      // walk pointer restarts on every change of state
      if (state != state_next) begin
        walk_idx <= '0;
      end else if (issue) begin
        walk_idx <= walk_idx + 1'b1;
      end
      chk_vld <= issue && (state == state_next);

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    chk_idx <= walk_idx[IDX_W-1:0];

    if (accept) begin
      sid    <= sender_id;
      sample <= rssi;
      found  <= 1'b0;
      alloc  <= 1'b0;
      best   <= FLOOR_LEVEL;
    end

    if (hit_now && !found) begin
      found  <= 1'b1;
      target <= chk_idx;
    end
    if ((state == ST_MATCH) && last && !found && !hit_now) begin
      // unknown id: next free slot, if any
      target <= slots_used[IDX_W-1:0];
      alloc  <= (slots_used < (IDX_W+1)'(NODES));
    end

    if (state == ST_SCALC) begin
      samp_hist <= hist_n;
      samp_cnt  <= cnt_n;
      samp_neg  <= sum_neg;
    end
    if ((state == ST_SDIV) && div_done) begin
      // truncation toward zero: divide magnitudes, then restore the sign
      samp_level <= samp_neg ? LEVEL_W'(-div_q[LEVEL_W-1:0]) : div_q[LEVEL_W-1:0];
    end

    if ((state == ST_AGE) && chk_vld && chk_in_table) begin
      if ((aged_lv != '0) && (aged_lv >= best)) best <= aged_lv;
    end

    if (out_load) strongest_rssi <= best;
  end

endmodule

// ===== src/nrt_checker.sv =====
module nrt_checker
  import nrt_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [LEVEL_W-1:0] strongest_rssi
);

  // a result never goes below the floor
  a_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (strongest_rssi >= FLOOR_LEVEL))
    else $error("strongest_rssi below floor");

  // zero means absent and is never reported
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (strongest_rssi != '0))
    else $error("strongest_rssi is zero");

  // one word in flight: no second word straight after an accept
  a_single: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("word accepted while busy");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(strongest_rssi)))
    else $error("result changed under stall");

endmodule

bind node_rssi_tracker_top nrt_checker u_nrt_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .strongest_rssi (strongest_rssi)
);
